// ===== rtl/core/smm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smm_pkg;

	typedef enum logic [2:0] {
		REG_MIN_GAMMA2 = 3'd0,
		REG_X_LOWER    = 3'd1,
		REG_X_UPPER    = 3'd2,
		REG_Y_LOWER    = 3'd3,
		REG_Y_UPPER    = 3'd4,
		REG_BOUND_MASK = 3'd5
	} cfg_reg_t;

	// one datapath operation per cycle, issued by the controller
	typedef enum logic [4:0] {
		OP_NONE     = 5'd0,
		OP_LOAD     = 5'd1,
		OP_BAD      = 5'd2,
		OP_GMUL     = 5'd3,
		OP_GACC     = 5'd4,
		OP_AMUL1    = 5'd5,
		OP_AMUL2    = 5'd6,
		OP_AMUL3    = 5'd7,
		OP_AMUL4    = 5'd8,
		OP_AMUL5    = 5'd9,
		OP_AWRITE   = 5'd10,
		OP_AFIN     = 5'd11,
		OP_DIV1     = 5'd12,
		OP_DIV1END  = 5'd13,
		OP_DIV2     = 5'd14,
		OP_DIV2END  = 5'd15,
		OP_SQMUL    = 5'd16,
		OP_SQACC    = 5'd17,
		OP_RSTORE   = 5'd18,
		OP_OUT      = 5'd19
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] comp;
		logic [1:0] part;
	} dp_cmd_t;

	typedef struct packed {
		logic sp_zero;
		logic sp_ok;
		logic region_ok;
		logic gamma_ok;
		logic rd_ok;
		logic div_busy;
		logic out_free;
	} dp_status_t;

	typedef struct packed {
		logic               command;
		logic [2:0]         species;
		logic [31:0]        weight;
		logic signed [31:0] mom_x;
		logic signed [31:0] mom_y;
		logic signed [31:0] mom_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} item_t;

	typedef struct packed {
		logic [2:0]         species_out;
		logic [63:0]        weight_total;
		logic [31:0]        particle_count;
		logic signed [31:0] mean_x;
		logic signed [31:0] mean_y;
		logic signed [31:0] mean_z;
		logic [63:0]        spread_x;
		logic [63:0]        spread_y;
		logic [63:0]        spread_z;
		logic               empty_res;
		logic [31:0]        invalid_count;
		logic [31:0]        last_accepted_index;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/smm_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface smm_req_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [2:0]         species;
	logic [31:0]        weight;
	logic signed [31:0] mom_x;
	logic signed [31:0] mom_y;
	logic signed [31:0] mom_z;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	modport source (output valid, command, species, weight, mom_x, mom_y, mom_z, pos_x, pos_y,
		input ready);
	modport sink (input valid, command, species, weight, mom_x, mom_y, mom_z, pos_x, pos_y,
		output ready);
endinterface

interface smm_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         species_out;
	logic [63:0]        weight_total;
	logic [31:0]        particle_count;
	logic signed [31:0] mean_x;
	logic signed [31:0] mean_y;
	logic signed [31:0] mean_z;
	logic [63:0]        spread_x;
	logic [63:0]        spread_y;
	logic [63:0]        spread_z;
	logic               empty_res;
	logic [31:0]        invalid_count;
	logic [31:0]        last_accepted_index;
	modport source (output valid, species_out, weight_total, particle_count, mean_x, mean_y,
		mean_z, spread_x, spread_y, spread_z, empty_res, invalid_count, last_accepted_index,
		input ready);
	modport sink (input valid, species_out, weight_total, particle_count, mean_x, mean_y,
		mean_z, spread_x, spread_y, spread_z, empty_res, invalid_count, last_accepted_index,
		output ready);
endinterface

interface smm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/smm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 128/64 restoring divider, one quotient bit per cycle, saturates when hi >= divisor
module smm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num_hi,
	input  logic [63:0] num_lo,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic [63:0] quo
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] lo_q;
	logic [63:0] d_q;
	logic [63:0] quo_q;
	logic [64:0] trial;
	logic [65:0] diff;
	logic        ge;

	always_comb begin
		trial = {rem_q, lo_q[63]};
		diff  = {1'b0, trial} - {2'b00, d_q};
		ge    = !diff[65];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= (num_hi < divisor);
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			lo_q  <= num_lo;
			d_q   <= divisor;
			quo_q <= (num_hi >= divisor) ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : trial[63:0];
			lo_q  <= {lo_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ===== rtl/core/smm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_command,
	output logic               req_ready,
	input  smm_pkg::dp_status_t st,
	output smm_pkg::dp_cmd_t   cmd
);
	import smm_pkg::*;

	typedef enum logic [21:0] {
		ST_IDLE  = 22'h000001,
		ST_CHECK = 22'h000002,
		ST_GMUL  = 22'h000004,
		ST_GACC  = 22'h000008,
		ST_GTEST = 22'h000010,
		ST_A1    = 22'h000020,
		ST_A2    = 22'h000040,
		ST_A3    = 22'h000080,
		ST_A4    = 22'h000100,
		ST_A5    = 22'h000200,
		ST_AWR   = 22'h000400,
		ST_AFIN  = 22'h000800,
		ST_RHEAD = 22'h001000,
		ST_RWAIT = 22'h002000,
		ST_D1    = 22'h004000,
		ST_D1W   = 22'h008000,
		ST_D2    = 22'h010000,
		ST_D2W   = 22'h020000,
		ST_SQ    = 22'h040000,
		ST_SACC  = 22'h080000,
		ST_RST   = 22'h100000,
		ST_OUT   = 22'h200000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] comp_q, comp_d;
	logic [1:0] part_q, part_d;
	dp_op_t     op;

	always_comb begin
		state_d   = state_q;
		comp_d    = comp_q;
		part_d    = part_q;
		op        = OP_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					op      = OP_LOAD;
					comp_d  = 2'd0;
					state_d = req_command ? ST_RHEAD : ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (st.sp_zero) begin
					op      = OP_BAD;
					state_d = ST_IDLE;
				end else if (!st.sp_ok || !st.region_ok) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_GMUL;
				end
			end
			ST_GMUL: begin
				op      = OP_GMUL;
				state_d = ST_GACC;
			end
			ST_GACC: begin
				op = OP_GACC;
				if (comp_q == 2'd2) begin
					comp_d  = 2'd0;
					state_d = ST_GTEST;
				end else begin
					comp_d  = comp_q + 2'd1;
					state_d = ST_GMUL;
				end
			end
			ST_GTEST: state_d = st.gamma_ok ? ST_A1 : ST_IDLE;
			ST_A1: begin
				op      = OP_AMUL1;
				state_d = ST_A2;
			end
			ST_A2: begin
				op      = OP_AMUL2;
				state_d = ST_A3;
			end
			ST_A3: begin
				op      = OP_AMUL3;
				state_d = ST_A4;
			end
			ST_A4: begin
				op      = OP_AMUL4;
				state_d = ST_A5;
			end
			ST_A5: begin
				op      = OP_AMUL5;
				state_d = ST_AWR;
			end
			ST_AWR: begin
				op = OP_AWRITE;
				if (comp_q == 2'd2) begin
					comp_d  = 2'd0;
					state_d = ST_AFIN;
				end else begin
					comp_d  = comp_q + 2'd1;
					state_d = ST_A1;
				end
			end
			ST_AFIN: begin
				op      = OP_AFIN;
				state_d = ST_IDLE;
			end
			ST_RHEAD: state_d = st.rd_ok ? ST_RWAIT : ST_OUT;
			ST_RWAIT: state_d = ST_D1;
			ST_D1: begin
				op      = OP_DIV1;
				state_d = ST_D1W;
			end
			ST_D1W: begin
				if (!st.div_busy) begin
					op      = OP_DIV1END;
					state_d = ST_D2;
				end
			end
			ST_D2: begin
				op      = OP_DIV2;
				state_d = ST_D2W;
			end
			ST_D2W: begin
				if (!st.div_busy) begin
					op      = OP_DIV2END;
					part_d  = 2'd0;
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				op      = OP_SQMUL;
				state_d = ST_SACC;
			end
			ST_SACC: begin
				op = OP_SQACC;
				if (part_q == 2'd3) begin
					state_d = ST_RST;
				end else begin
					part_d  = part_q + 2'd1;
					state_d = ST_SQ;
				end
			end
			ST_RST: begin
				op = OP_RSTORE;
				if (comp_q == 2'd2) begin
					state_d = ST_OUT;
				end else begin
					comp_d  = comp_q + 2'd1;
					state_d = ST_RWAIT;
				end
			end
			ST_OUT: begin
				if (st.out_free) begin
					op      = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			comp_q  <= 2'd0;
			part_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			comp_q  <= comp_d;
			part_q  <= part_d;
		end
	end

	assign cmd.op   = op;
	assign cmd.comp = comp_q;
	assign cmd.part = part_q;
endmodule
`default_nettype wire

// ===== rtl/core/smm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smm_dp #(
	parameter int NSPECIES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smm_pkg::item_t     item,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  smm_pkg::dp_cmd_t   cmd,
	output smm_pkg::dp_status_t st,
	output smm_pkg::result_t   res,
	output logic               res_valid,
	input  logic               res_ready
);
	import smm_pkg::*;

	localparam int KW       = (NSPECIES > 1) ? $clog2(NSPECIES) : 1;
	localparam int MomDepth = 3 * NSPECIES;
	localparam int AW       = $clog2(MomDepth);

	// configuration
	logic [31:0]        min_g2_q;
	logic signed [31:0] xlo_q, xup_q, ylo_q, yup_q;
	logic [15:0]        mask_q;

	// accumulated state
	logic [63:0] weight_q [NSPECIES];
	logic [31:0] count_q [NSPECIES];
	logic        rowv_q [NSPECIES];
	logic [31:0] bad_q, stream_q, last_q;
	logic [63:0] m1_mem [MomDepth];
	logic [63:0] m2_mem [MomDepth];
	logic [63:0] rd1_q, rd2_q;
	logic        rdv_q;

	// current item
	logic [2:0]         sp_q;
	logic [31:0]        w_q;
	logic signed [31:0] mom_q [3];
	logic signed [31:0] px_q, py_q;
	logic [31:0]        idx_q;

	// work registers
	logic [63:0]        prod_q;
	logic [63:0]        g2_q;
	logic [47:0]        t1_q;
	logic [31:0]        mmhi_q;
	logic [63:0]        pl_q;
	logic [63:0]        t2_q;
	logic [63:0]        m_q, e2_q;
	logic               neg_q;
	logic [127:0]       acc_q;
	logic signed [31:0] mean_q [3];
	logic [63:0]        spread_q [3];
	result_t            res_q;
	logic               res_valid_q;

	logic [2:0]   k3;
	logic [KW-1:0] k;
	logic [3:0]   en;
	logic         sp_ok;
	logic [AW-1:0] addr;
	logic [31:0]  mag_sel;
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  s1_rd, s2_rd, mag1;
	logic [63:0]  w_sel;
	logic         rd_ok;
	logic         mem_we;
	logic [63:0]  t_signed;
	logic [64:0]  s1_sum, s2_sum, w_sum;
	logic [63:0]  s1_new, s2_new;
	logic [95:0]  full96;
	logic [63:0]  msq;
	logic [47:0]  q48;
	logic [31:0]  mean_new;
	logic [127:0] pp_shift;
	logic         div_start, div_busy;
	logic [63:0]  div_hi, div_lo, div_quo;

	always_comb begin
		k3    = sp_q - 3'd1;
		k     = KW'(k3);
		sp_ok = (sp_q != 3'd0) && (32'(sp_q) <= NSPECIES);
		en    = k3[2] ? 4'd0 : 4'(mask_q >> {k3[1:0], 2'b00});
		addr  = AW'(6'(k3) * 6'd3 + 6'(cmd.comp));
		mag_sel = mom_q[cmd.comp][31] ? (32'd0 - 32'(mom_q[cmd.comp])) : 32'(mom_q[cmd.comp]);
		s1_rd = rdv_q ? rd1_q : 64'd0;
		s2_rd = rdv_q ? rd2_q : 64'd0;
		mag1  = s1_rd[63] ? (64'd0 - s1_rd) : s1_rd;
		w_sel = sp_ok ? weight_q[k] : 64'd0;
		rd_ok = sp_ok && (w_sel != 64'd0);
		mem_we = (cmd.op == OP_AWRITE);
	end

	// shared 32x32 multiplier
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		unique case (cmd.op)
			OP_GMUL, OP_AMUL2: begin
				mul_a = mag_sel;
				mul_b = mag_sel;
			end
			OP_AMUL1: begin
				mul_a = mag_sel;
				mul_b = w_q;
			end
			OP_AMUL3: begin
				mul_a = prod_q[31:0];
				mul_b = w_q;
			end
			OP_AMUL4: begin
				mul_a = mmhi_q;
				mul_b = w_q;
			end
			OP_SQMUL: begin
				mul_a = cmd.part[1] ? m_q[63:32] : m_q[31:0];
				mul_b = cmd.part[0] ? m_q[63:32] : m_q[31:0];
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	always_comb begin
		t_signed = mom_q[cmd.comp][31] ? (64'd0 - 64'(t1_q)) : 64'(t1_q);
		s1_sum   = {s1_rd[63], s1_rd} + {t_signed[63], t_signed};
		if (s1_sum[64] != s1_sum[63]) begin
			s1_new = s1_sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end else begin
			s1_new = s1_sum[63:0];
		end
		s2_sum = {1'b0, s2_rd} + {1'b0, t2_q};
		s2_new = s2_sum[64] ? '1 : s2_sum[63:0];
		w_sum  = {1'b0, weight_q[k]} + 65'(w_q);
		full96 = {prod_q, 32'd0} + {32'd0, pl_q};
		msq    = (acc_q[127:96] != 32'd0) ? '1 : acc_q[95:32];
		q48    = m_q[63:16];
		if (neg_q) begin
			mean_new = 32'd0 - ((q48 > 48'h8000_0000) ? 32'h8000_0000 : q48[31:0]);
		end else begin
			mean_new = (q48 > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : q48[31:0];
		end
		unique case (cmd.part)
			2'd0:    pp_shift = 128'(prod_q);
			2'd3:    pp_shift = 128'(prod_q) << 64;
			default: pp_shift = 128'(prod_q) << 32;
		endcase
	end

	// divider operands
	always_comb begin
		div_start = (cmd.op == OP_DIV1) || (cmd.op == OP_DIV2);
		if (cmd.op == OP_DIV1) begin
			div_hi = {32'd0, mag1[63:32]};
			div_lo = {mag1[31:0], 32'd0};
		end else begin
			div_hi = {48'd0, s2_rd[63:48]};
			div_lo = {s2_rd[47:0], 16'd0};
		end
	end

	smm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_hi  (div_hi),
		.num_lo  (div_lo),
		.divisor (w_sel),
		.busy    (div_busy),
		.quo     (div_quo)
	);

	// moment memories, read address follows species and component
	always_ff @(posedge clk) begin
		if (mem_we) begin
			m1_mem[addr] <= s1_new;
			m2_mem[addr] <= s2_new;
		end
		rd1_q <= m1_mem[addr];
		rd2_q <= m2_mem[addr];
		rdv_q <= rowv_q[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_g2_q    <= '0;
			xlo_q       <= '0;
			xup_q       <= '0;
			ylo_q       <= '0;
			yup_q       <= '0;
			mask_q      <= '0;
			bad_q       <= '0;
			stream_q    <= '0;
			last_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NSPECIES; i++) begin
				weight_q[i] <= '0;
				count_q[i]  <= '0;
				rowv_q[i]   <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_MIN_GAMMA2: min_g2_q <= cfg_data;
					REG_X_LOWER:    xlo_q    <= cfg_data;
					REG_X_UPPER:    xup_q    <= cfg_data;
					REG_Y_LOWER:    ylo_q    <= cfg_data;
					REG_Y_UPPER:    yup_q    <= cfg_data;
					REG_BOUND_MASK: mask_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_LOAD && !item.command) begin
				stream_q <= stream_q + 32'd1;
			end
			if (cmd.op == OP_BAD && bad_q != '1) begin
				bad_q <= bad_q + 32'd1;
			end
			if (cmd.op == OP_AFIN) begin
				weight_q[k] <= w_sum[64] ? '1 : w_sum[63:0];
				if (count_q[k] != '1) begin
					count_q[k] <= count_q[k] + 32'd1;
				end
				rowv_q[k] <= 1'b1;
				last_q    <= idx_q;
			end
			if (cmd.op == OP_OUT) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		unique case (cmd.op)
			OP_LOAD: begin
				sp_q     <= item.species;
				w_q      <= item.weight;
				mom_q[0] <= item.mom_x;
				mom_q[1] <= item.mom_y;
				mom_q[2] <= item.mom_z;
				px_q     <= item.pos_x;
				py_q     <= item.pos_y;
				idx_q    <= stream_q;
				g2_q     <= 64'h1_0000_0000;
				for (int i = 0; i < 3; i++) begin
					mean_q[i]   <= '0;
					spread_q[i] <= '0;
				end
			end
			OP_GACC:    g2_q   <= g2_q + prod_q;
			OP_AMUL2:   t1_q   <= prod_q[63:16];
			OP_AMUL3:   mmhi_q <= prod_q[63:32];
			OP_AMUL4:   pl_q   <= prod_q;
			OP_AMUL5:   t2_q   <= (full96[95:80] != 16'd0) ? '1 : full96[79:16];
			OP_DIV1:    neg_q  <= s1_rd[63];
			OP_DIV1END: m_q    <= div_quo;
			OP_DIV2END: begin
				e2_q  <= div_quo;
				acc_q <= '0;
			end
			OP_SQACC:   acc_q <= acc_q + pp_shift;
			OP_RSTORE: begin
				spread_q[cmd.comp] <= (e2_q > msq) ? (e2_q - msq) : 64'd0;
				mean_q[cmd.comp]   <= mean_new;
			end
			OP_OUT: begin
				res_q.species_out         <= sp_q;
				res_q.weight_total        <= w_sel;
				res_q.particle_count      <= sp_ok ? count_q[k] : 32'd0;
				res_q.mean_x              <= mean_q[0];
				res_q.mean_y              <= mean_q[1];
				res_q.mean_z              <= mean_q[2];
				res_q.spread_x            <= spread_q[0];
				res_q.spread_y            <= spread_q[1];
				res_q.spread_z            <= spread_q[2];
				res_q.empty_res           <= !rd_ok;
				res_q.invalid_count       <= bad_q;
				res_q.last_accepted_index <= last_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		st.sp_zero   = (sp_q == 3'd0);
		st.sp_ok     = sp_ok;
		st.region_ok = (!en[0] || (px_q > xlo_q)) && (!en[1] || (px_q < xup_q))
			&& (!en[2] || (py_q > ylo_q)) && (!en[3] || (py_q < yup_q));
		st.gamma_ok  = (g2_q >= {16'd0, min_g2_q, 16'd0});
		st.rd_ok     = rd_ok;
		st.div_busy  = div_busy;
		st.out_free  = !res_valid_q || res_ready;
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;
endmodule
`default_nettype wire

// ===== rtl/core/species_momentum_moments.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Per-species weighted momentum moments. Particle items (command 0) are filtered by the
// enabled x/y bounds and the gamma^2 threshold, then summed into saturating per-species
// weight, count, momentum and squared-momentum accumulators; readout items (command 1)
// return weighted means (Q16.16) and variances (Q32.32) of one species. One item is in
// work at a time, run by a sequencer over a shared 32x32 multiplier: a particle is rejected by
// species or region, or after the gamma check, or is accumulated (gamma check plus five steps,
// four multiplications and a combine, and a moment-memory write per component). A readout runs
// two 64-step divisions per component on the bit-serial divider; an empty or out-of-range
// species skips them and goes straight to the result. The result register lets the next item
// in while a result waits. Configuration writes are always accepted and must be made while
// the block is idle.
module species_momentum_moments #(
	parameter int NSPECIES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	smm_req_if.sink   req,
	smm_rsp_if.source rsp,
	smm_cfg_if.sink   cfg
);
	import smm_pkg::*;

	item_t      item;
	dp_cmd_t    cmd;
	dp_status_t st;
	result_t    res;
	logic       res_valid;
	logic       req_ready;

	assign item.command = req.command;
	assign item.species = req.species;
	assign item.weight  = req.weight;
	assign item.mom_x   = req.mom_x;
	assign item.mom_y   = req.mom_y;
	assign item.mom_z   = req.mom_z;
	assign item.pos_x   = req.pos_x;
	assign item.pos_y   = req.pos_y;
	assign req.ready    = req_ready;
	assign cfg.ready    = 1'b1;

	smm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req_ready),
		.st          (st),
		.cmd         (cmd)
	);

	smm_dp #(
		.NSPECIES (NSPECIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.st        (st),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (rsp.ready)
	);

	assign rsp.valid               = res_valid;
	assign rsp.species_out         = res.species_out;
	assign rsp.weight_total        = res.weight_total;
	assign rsp.particle_count      = res.particle_count;
	assign rsp.mean_x              = res.mean_x;
	assign rsp.mean_y              = res.mean_y;
	assign rsp.mean_z              = res.mean_z;
	assign rsp.spread_x            = res.spread_x;
	assign rsp.spread_y            = res.spread_y;
	assign rsp.spread_z            = res.spread_z;
	assign rsp.empty_res           = res.empty_res;
	assign rsp.invalid_count       = res.invalid_count;
	assign rsp.last_accepted_index = res.last_accepted_index;
endmodule
`default_nettype wire
